@@ design/assert_macros.svh @@
// Assertion macros shared by the texture page valid tracker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge of clk outside reset.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge of clk outside reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/tpvt_pkg.sv @@
// Types, codes and constants shared by the texture page valid tracker.
package tpvt_pkg;

    // Request function codes.
    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_INVAL  = 1'b1;

    // Colour depth codes.
    localparam logic [1:0] DEPTH_4BPP  = 2'd0;
    localparam logic [1:0] DEPTH_8BPP  = 2'd1;
    localparam logic [1:0] DEPTH_16BPP = 2'd2;
    localparam logic [1:0] DEPTH_BAD   = 2'd3;

    // Page geometry.
    localparam int NUM_DEPTHS     = 3;
    localparam int PAGE_ROWS      = 2;
    localparam int ROW_BITS       = 16;
    localparam int MASK_W         = PAGE_ROWS * ROW_BITS;
    localparam int PAGE_STEP      = 64;
    localparam int PAGE_ROW_SPAN  = 256;
    localparam int FB_WIDTH       = 1024;
    localparam int FB_HEIGHT      = 512;

    typedef logic [MASK_W-1:0] mask_t;
    typedef mask_t [NUM_DEPTHS-1:0] mask_set_t;

    // One request as held in the input register.
    typedef struct packed {
        logic        func;
        logic [1:0]  page_format;
        logic [3:0]  page_col;
        logic        page_row;
        logic [9:0]  rect_left;
        logic [8:0]  rect_top;
        logic [10:0] rect_right;
        logic [9:0]  rect_bottom;
    } cmd_t;

    // One result as held in the output register.
    typedef struct packed {
        logic       hit;
        logic       fill_request;
        logic [1:0] fill_depth;
        logic       bad_format;
    } result_t;

    // Page width in framebuffer columns for each depth: 64, 128 or 256.
    function automatic logic [8:0] depth_span(input int d);
        logic [8:0] span;
        span = 9'(PAGE_STEP << d);
        return span;
    endfunction

endpackage

@@ design/tpvt_overlap.sv @@
// Rectangle to page overlap decoder: builds the per-depth clear masks.
module tpvt_overlap #(
    parameter int PAGE_COLUMNS = 16
) (
    input  logic [9:0]          rect_left,
    input  logic [8:0]          rect_top,
    input  logic [10:0]         rect_right,
    input  logic [9:0]          rect_bottom,
    output tpvt_pkg::mask_set_t clr_mask
);
    import tpvt_pkg::*;

    logic [10:0] right_c;
    logic [9:0]  bottom_c;
    logic [PAGE_ROWS-1:0] row_hit;
    logic [9:0]  row_y;
    logic [10:0] row_end;
    logic [10:0] col_x;
    logic [11:0] col_end;
    logic        col_on;

    // Clamp the exclusive edges to the framebuffer size.
    always_comb
    begin
        right_c  = (rect_right > 11'(FB_WIDTH)) ? 11'(FB_WIDTH) : rect_right;
        bottom_c = (rect_bottom > 10'(FB_HEIGHT)) ? 10'(FB_HEIGHT) : rect_bottom;
    end

    // Each page is tested on its own; all compares run side by side.
    always_comb
    begin
        clr_mask = '0;
        row_y    = '0;
        row_end  = '0;
        col_x    = '0;
        col_end  = '0;
        col_on   = 1'b0;
        for (int r = 0; r < PAGE_ROWS; r++)
        begin
            row_y      = 10'(r * PAGE_ROW_SPAN);
            row_end    = 11'((r + 1) * PAGE_ROW_SPAN);
            row_hit[r] = (row_y < bottom_c) && ({2'b00, rect_top} < row_end);
            for (int c = 0; c < ROW_BITS; c++)
            begin
                col_x  = 11'(c * PAGE_STEP);
                col_on = (c < PAGE_COLUMNS) && (col_x < right_c);
                for (int d = 0; d < NUM_DEPTHS; d++)
                begin
                    col_end = 12'(c * PAGE_STEP) + {3'b000, depth_span(d)};
                    clr_mask[d][r*ROW_BITS + c] = row_hit[r] && col_on
                        && ({2'b00, rect_left} < col_end);
                end
            end
        end
    end

endmodule

@@ design/tpvt_valid_store.sv @@
// Valid bit store: per-depth page masks, lookup result and mask update.
`include "assert_macros.svh"

module tpvt_valid_store #(
    parameter int PAGE_COLUMNS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                update_en,
    input  tpvt_pkg::cmd_t      cmd,
    input  tpvt_pkg::mask_set_t clr_mask,
    output tpvt_pkg::result_t   result
);
    import tpvt_pkg::*;

    mask_set_t   mask_reg;
    mask_set_t   mask_next;
    mask_t       cur_mask;
    logic [4:0]  bit_idx;
    logic        col_ok;
    logic        fill;

    assign bit_idx = {cmd.page_row, cmd.page_col};
    assign col_ok  = int'(cmd.page_col) < PAGE_COLUMNS;

    // Select the mask of the named depth.
    always_comb
    begin
        unique case (cmd.page_format)
            DEPTH_4BPP:  cur_mask = mask_reg[0];
            DEPTH_8BPP:  cur_mask = mask_reg[1];
            DEPTH_16BPP: cur_mask = mask_reg[2];
            default:     cur_mask = '0;
        endcase
    end

    // Lookup result; an invalidate gives all zeros.
    always_comb
    begin
        result = '0;
        fill   = 1'b0;
        if (cmd.func == FUNC_LOOKUP)
        begin
            if (cmd.page_format == DEPTH_BAD)
            begin
                result.bad_format = 1'b1;
            end
            else if (col_ok)
            begin
                if (cur_mask[bit_idx])
                begin
                    result.hit = 1'b1;
                end
                else
                begin
                    fill                = 1'b1;
                    result.fill_request = 1'b1;
                    result.fill_depth   = cmd.page_format;
                end
            end
        end
    end

    // Clear overlapped pages on an invalidate, set the page on a fill.
    always_comb
    begin
        mask_next = mask_reg;
        if (update_en)
        begin
            for (int d = 0; d < NUM_DEPTHS; d++)
            begin
                if (cmd.func == FUNC_INVAL)
                begin
                    mask_next[d] = mask_reg[d] & ~clr_mask[d];
                end
                else if (fill && (cmd.page_format == 2'(d)))
                begin
                    mask_next[d][bit_idx] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else
        begin
            mask_reg <= mask_next;
        end
    end

    `ASSERT_NEXT(a_hold_when_idle, !update_en, $stable(mask_reg), "masks changed without a request")
    `ASSERT_NEXT(a_inval_clears, update_en && (cmd.func == FUNC_INVAL), (mask_reg & $past(clr_mask)) == '0, "invalidate left an overlapped page valid")
    `ASSERT_NEXT(a_fill_adds_one, update_en && fill, $countones(mask_reg) == $past($countones(mask_reg)) + 1, "fill did not set exactly one page")

endmodule

@@ design/texture_page_valid_tracker.sv @@
// Top level of the texture page valid tracker: input register, store, result register.
// Texture page valid tracker. Each request is either a page lookup (hit, or a fill
// request that also marks the page valid; depth code 3 returns bad_format) or a
// framebuffer rectangle invalidate that clears every overlapped page at all three
// depths. Every request yields exactly one result. The block takes one request per
// clock while in_ready is high: a request sits in the input register, where the
// overlap decode and the valid-mask read and update happen, and moves to the result
// register, raising out_valid, once that register is empty or being read out.
// in_ready drops only when both registers are full and out_ready is low. The valid
// masks are cleared by reset.
`include "assert_macros.svh"

module texture_page_valid_tracker #(
    parameter int PAGE_COLUMNS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic [1:0]  page_format,
    input  logic [3:0]  page_col,
    input  logic        page_row,
    input  logic [9:0]  rect_left,
    input  logic [8:0]  rect_top,
    input  logic [10:0] rect_right,
    input  logic [9:0]  rect_bottom,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        hit,
    output logic        fill_request,
    output logic [1:0]  fill_depth,
    output logic        bad_format
);
    import tpvt_pkg::*;

    logic      s1_valid_reg;
    cmd_t      cmd_reg;
    logic      out_valid_reg;
    result_t   result_reg;
    result_t   result_next;
    mask_set_t clr_mask;
    logic      s1_advance;

    // Pipeline flow control.
    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || !out_valid_reg || out_ready;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg <= '{func:        func,
                         page_format: page_format,
                         page_col:    page_col,
                         page_row:    page_row,
                         rect_left:   rect_left,
                         rect_top:    rect_top,
                         rect_right:  rect_right,
                         rect_bottom: rect_bottom};
        end
    end

    // Overlap decode of the held rectangle.
    tpvt_overlap #(
        .PAGE_COLUMNS (PAGE_COLUMNS)
    ) u_overlap (
        .rect_left   (cmd_reg.rect_left),
        .rect_top    (cmd_reg.rect_top),
        .rect_right  (cmd_reg.rect_right),
        .rect_bottom (cmd_reg.rect_bottom),
        .clr_mask    (clr_mask)
    );

    // Valid masks; updated when the request moves to the result register.
    tpvt_valid_store #(
        .PAGE_COLUMNS (PAGE_COLUMNS)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .update_en (s1_advance),
        .cmd       (cmd_reg),
        .clr_mask  (clr_mask),
        .result    (result_next)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign hit          = result_reg.hit;
    assign fill_request = result_reg.fill_request;
    assign fill_depth   = result_reg.fill_depth;
    assign bad_format   = result_reg.bad_format;

    `ASSERT_NEXT(a_stalled_request_kept, s1_valid_reg && !s1_advance, s1_valid_reg, "held request was dropped")
    `ASSERT_IMPLY(a_one_outcome, out_valid_reg, $countones({hit, fill_request, bad_format}) <= 1, "result shows more than one outcome")

endmodule

@@ sim/texture_page_valid_tracker_tb.sv @@
// Self-checking testbench for the texture page valid tracker.
`timescale 1ns / 100ps

module texture_page_valid_tracker_tb;

    import tpvt_pkg::*;

    localparam int PAGE_COLS   = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_REQS = 400;
    localparam int DRAIN_AT    = 250;
    localparam int HOLD_AFTER  = 150;
    localparam int HOLD_CYCLES = 150;
    localparam int MAX_GAP     = 8;
    localparam int MAX_REPORTS = 10;

    // A request waiting to be sent, with a flag that makes the sender drain first.
    typedef struct packed {
        logic drain;
        cmd_t req;
    } staged_request_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        func = 1'b0;
    logic [1:0]  page_format = 2'd0;
    logic [3:0]  page_col = 4'd0;
    logic        page_row = 1'b0;
    logic [9:0]  rect_left = 10'd0;
    logic [8:0]  rect_top = 9'd0;
    logic [10:0] rect_right = 11'd0;
    logic [9:0]  rect_bottom = 10'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        hit;
    logic        fill_request;
    logic [1:0]  fill_depth;
    logic        bad_format;

    staged_request_t pending_requests[$];
    result_t         expected_results[$];
    mask_t           page_valid[NUM_DEPTHS];

    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    bit          sender_burst = 1'b0;
    bit          receiver_burst = 1'b0;
    int unsigned requests_sent = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    int unsigned n_hits = 0;
    int unsigned n_fills = 0;
    int unsigned n_bad = 0;
    int unsigned n_inval = 0;

    cmd_t            accepted_req;
    result_t         predicted;
    staged_request_t next_item;
    result_t         oldest;

    texture_page_valid_tracker #(
        .PAGE_COLUMNS(PAGE_COLS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .func(func),
        .page_format(page_format),
        .page_col(page_col),
        .page_row(page_row),
        .rect_left(rect_left),
        .rect_top(rect_top),
        .rect_right(rect_right),
        .rect_bottom(rect_bottom),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .hit(hit),
        .fill_request(fill_request),
        .fill_depth(fill_depth),
        .bad_format(bad_format)
    );

    always #6 clk = ~clk;

    // Applies one request to the local copy of the valid masks and returns its result.
    function automatic result_t resolve_request(input cmd_t c);
        result_t r;
        int      right_c;
        int      bottom_c;
        int      x;
        int      y;
        int      idx;
        r = '0;
        if (c.func == FUNC_INVAL)
        begin
            right_c  = (int'(c.rect_right) > FB_WIDTH) ? FB_WIDTH : int'(c.rect_right);
            bottom_c = (int'(c.rect_bottom) > FB_HEIGHT) ? FB_HEIGHT : int'(c.rect_bottom);
            for (int row = 0; row < PAGE_ROWS; row++)
            begin
                y = row * PAGE_ROW_SPAN;
                if (y < bottom_c && int'(c.rect_top) < y + PAGE_ROW_SPAN)
                begin
                    for (int col = 0; col < PAGE_COLS && col < ROW_BITS; col++)
                    begin
                        x = col * PAGE_STEP;
                        if (x < right_c)
                        begin
                            // A wider page reaches further right, so it overlaps sooner.
                            for (int d = 0; d < NUM_DEPTHS; d++)
                            begin
                                if (int'(c.rect_left) < x + (PAGE_STEP << d))
                                    page_valid[d][row * ROW_BITS + col] = 1'b0;
                            end
                        end
                    end
                end
            end
        end
        else if (c.page_format == DEPTH_BAD)
        begin
            r.bad_format = 1'b1;
        end
        else if (int'(c.page_col) < PAGE_COLS)
        begin
            idx = int'(c.page_row) * ROW_BITS + int'(c.page_col);
            if (page_valid[c.page_format][idx])
            begin
                r.hit = 1'b1;
            end
            else
            begin
                page_valid[c.page_format][idx] = 1'b1;
                r.fill_request = 1'b1;
                r.fill_depth   = c.page_format;
            end
        end
        return r;
    endfunction

    // Appends one request to the sender's queue.
    task automatic add_request(input logic f, input logic [1:0] fmt, input logic [3:0] col,
                               input logic row, input logic [9:0] l, input logic [8:0] t,
                               input logic [10:0] r, input logic [9:0] b, input logic drain);
        staged_request_t s;
        s.drain = drain;
        s.req   = {f, fmt, col, row, l, t, r, b};
        pending_requests.push_back(s);
    endtask

    // Sender: records each accepted request and offers the next one after its gap.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                accepted_req = {func, page_format, page_col, page_row,
                                rect_left, rect_top, rect_right, rect_bottom};
                predicted = resolve_request(accepted_req);
                expected_results.push_back(predicted);
                requests_sent <= requests_sent + 1;
                if (accepted_req.func == FUNC_INVAL)
                    n_inval++;
                else if (predicted.bad_format)
                    n_bad++;
                else if (predicted.hit)
                    n_hits++;
                else if (predicted.fill_request)
                    n_fills++;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left != 0)
                begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (pending_requests.size() != 0 &&
                         !(pending_requests[0].drain && expected_results.size() != 0))
                begin
                    next_item = pending_requests.pop_front();
                    {func, page_format, page_col, page_row,
                     rect_left, rect_top, rect_right, rect_bottom} <= next_item.req;
                    in_valid <= 1'b1;
                    gap_left <= sender_burst ? 0 : $urandom_range(0, MAX_GAP);
                    if ($urandom_range(0, 39) == 0)
                        sender_burst <= ~sender_burst;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // One long receiver hold-off once traffic is well under way.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && requests_sent >= HOLD_AFTER)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver: checks each result against the oldest expectation, then stalls a random gap unless in burst mode.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("[%0t] result with no request outstanding: hit=%0b fill=%0b",
                                 $realtime, hit, fill_request);
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    if (hit !== oldest.hit || fill_request !== oldest.fill_request ||
                        fill_depth !== oldest.fill_depth || bad_format !== oldest.bad_format)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                        begin
                            $display("[%0t] result %0d mismatch: expected hit=%0b fill=%0b",
                                     $realtime, results_seen, oldest.hit,
                                     oldest.fill_request);
                            $display("    expected depth=%0d bad=%0b, got hit=%0b fill=%0b",
                                     oldest.fill_depth, oldest.bad_format, hit,
                                     fill_request);
                            $display("    got depth=%0d bad=%0b", fill_depth, bad_format);
                        end
                    end
                end
                if (receiver_burst)
                begin
                    stall_left <= 0;
                    out_ready  <= (hold_left == 0);
                end
                else
                begin
                    stall_left <= $urandom_range(0, MAX_GAP);
                    out_ready  <= 1'b0;
                end
                if ($urandom_range(0, 39) == 0)
                    receiver_burst <= ~receiver_burst;
            end
            else if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                out_ready  <= (stall_left == 1) && (hold_left == 0);
            end
            else
            begin
                out_ready <= (hold_left == 0);
            end
        end
    end

    // Watchdog on the whole run.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles with %0d results outstanding",
                 cycle_count, expected_results.size());
        $display("CHECKS FAILED");
        $finish;
    end

    // Stimulus, reset and end of run.
    initial
    begin
        logic        rf;
        logic [1:0]  rfmt;
        logic [3:0]  rcol;
        logic        rrow;
        logic [9:0]  rl;
        logic [8:0]  rt;
        logic [10:0] rr;
        logic [9:0]  rb;
        int unsigned pick;

        for (int d = 0; d < NUM_DEPTHS; d++)
            page_valid[d] = '0;

        // Directed: corner pages at each depth, a repeat hit and the bad depth code.
        add_request(FUNC_LOOKUP, DEPTH_4BPP, 4'd0, 1'b0, 10'd0, 9'd0, 11'd0, 10'd0, 1'b0);
        add_request(FUNC_LOOKUP, DEPTH_4BPP, 4'd0, 1'b0, 10'h3FF, 9'h1FF, 11'h7FF, 10'h3FF, 1'b0);
        add_request(FUNC_LOOKUP, DEPTH_8BPP, 4'd15, 1'b1, 10'd0, 9'd0, 11'd0, 10'd0, 1'b0);
        add_request(FUNC_LOOKUP, DEPTH_16BPP, 4'd15, 1'b1, 10'd0, 9'd0, 11'd0, 10'd0, 1'b0);
        add_request(FUNC_LOOKUP, DEPTH_16BPP, 4'd0, 1'b0, 10'd0, 9'd0, 11'd0, 10'd0, 1'b0);
        add_request(FUNC_LOOKUP, DEPTH_16BPP, 4'd1, 1'b0, 10'd0, 9'd0, 11'd0, 10'd0, 1'b0);
        add_request(FUNC_LOOKUP, DEPTH_BAD, 4'd0, 1'b0, 10'd0, 9'd0, 11'd0, 10'd0, 1'b0);
        add_request(FUNC_LOOKUP, DEPTH_BAD, 4'd15, 1'b1, 10'h3FF, 9'h1FF, 11'h7FF, 10'h3FF, 1'b0);
        add_request(FUNC_LOOKUP, DEPTH_4BPP, 4'd0, 1'b0, 10'd0, 9'd0, 11'd0, 10'd0, 1'b0);
        // Bottom-right corner with both far edges above the saturation point.
        add_request(FUNC_INVAL, DEPTH_4BPP, 4'd0, 1'b0, 10'd1023, 9'd511, 11'h7FF, 10'h3FF, 1'b0);
        add_request(FUNC_LOOKUP, DEPTH_8BPP, 4'd15, 1'b1, 10'd0, 9'd0, 11'd0, 10'd0, 1'b0);
        add_request(FUNC_LOOKUP, DEPTH_16BPP, 4'd15, 1'b1, 10'd0, 9'd0, 11'd0, 10'd0, 1'b0);
        // Right edge left of the left edge: only wide pages near the origin are hit.
        add_request(FUNC_INVAL, DEPTH_8BPP, 4'd3, 1'b1, 10'd200, 9'd0, 11'd100, 10'd600, 1'b0);
        add_request(FUNC_LOOKUP, DEPTH_16BPP, 4'd0, 1'b0, 10'd0, 9'd0, 11'd0, 10'd0, 1'b0);
        add_request(FUNC_LOOKUP, DEPTH_16BPP, 4'd1, 1'b0, 10'd0, 9'd0, 11'd0, 10'd0, 1'b0);
        add_request(FUNC_LOOKUP, DEPTH_4BPP, 4'd0, 1'b0, 10'd0, 9'd0, 11'd0, 10'd0, 1'b0);
        // Empty rectangle at the origin clears nothing; the full screen clears all.
        add_request(FUNC_INVAL, DEPTH_4BPP, 4'd0, 1'b0, 10'd0, 9'd0, 11'd0, 10'd0, 1'b0);
        add_request(FUNC_LOOKUP, DEPTH_4BPP, 4'd0, 1'b0, 10'd0, 9'd0, 11'd0, 10'd0, 1'b0);
        add_request(FUNC_INVAL, DEPTH_4BPP, 4'd0, 1'b0, 10'd0, 9'd0, 11'd1024, 10'd512, 1'b0);
        add_request(FUNC_LOOKUP, DEPTH_4BPP, 4'd0, 1'b0, 10'd0, 9'd0, 11'd0, 10'd0, 1'b0);
        add_request(FUNC_INVAL, DEPTH_BAD, 4'd15, 1'b1, 10'd0, 9'd0, 11'h7FF, 10'h3FF, 1'b0);
        add_request(FUNC_LOOKUP, DEPTH_8BPP, 4'd15, 1'b1, 10'd0, 9'd0, 11'd0, 10'd0, 1'b0);

        // Random: mostly valid lookups and modest rectangles, some raw noise.
        for (int i = 0; i < RANDOM_REQS; i++)
        begin
            rl   = 10'($urandom_range(0, 1023));
            rt   = 9'($urandom_range(0, 511));
            rr   = 11'($urandom);
            rb   = 10'($urandom);
            rcol = 4'($urandom);
            rrow = 1'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                rf   = FUNC_LOOKUP;
                rfmt = 2'($urandom_range(0, 2));
            end
            else if (pick < 80)
            begin
                rf   = FUNC_INVAL;
                rfmt = 2'($urandom);
                rr   = 11'(rl + $urandom_range(1, 300));
                rb   = 10'(rt + $urandom_range(1, 300));
                if ($urandom_range(0, 9) == 0)
                    rr = 11'($urandom_range(1024, 2047));
            end
            else
            begin
                rf   = 1'($urandom);
                rfmt = 2'($urandom);
            end
            add_request(rf, rfmt, rcol, rrow, rl, rt, rr, rb, i == DRAIN_AT);
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_requests.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (expected_results.size() != 0)
            mismatches += expected_results.size();

        $display("Sent %0d requests: %0d hits, %0d fills, %0d bad-depth lookups, %0d invalidates",
                 requests_sent, n_hits, n_fills, n_bad, n_inval);
        $display("Checked %0d results with %0d errors, including one long output stall",
                 results_seen, mismatches);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+design
design/tpvt_pkg.sv
design/tpvt_overlap.sv
design/tpvt_valid_store.sv
design/texture_page_valid_tracker.sv
sim/texture_page_valid_tracker_tb.sv
